>>> design/request_tag_tracker_defines.svh
// Assertion macros shared by the request tag tracker.
`ifndef REQUEST_TAG_TRACKER_DEFINES_SVH
`define REQUEST_TAG_TRACKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RTT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rtt_pkg.sv
package rtt_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TAG_W   = 8;
  localparam int DEPTH_W = 7;
  localparam int COUNT_W = 7;
  localparam int TIME_W  = 64;
  localparam int CFG_W   = 64;

  localparam logic [DEPTH_W-1:0] ACTIVE_DEPTH_RST  = 7'd64;
  localparam logic [TIME_W-1:0]  TIMEOUT_LIMIT_RST = '0;

  typedef enum logic [1:0] {
    ST_WAITING      = 2'd0,
    ST_TRANSFERRING = 2'd1,
    ST_COMPLETING   = 2'd2,
    ST_FAILED       = 2'd3
  } tag_state_t;

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_REARM    = 2'd2,
    KIND_EXPIRY   = 2'd3
  } kind_t;

  typedef enum logic {
    REG_ACTIVE_DEPTH  = 1'b0,
    REG_TIMEOUT_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t              kind;
    logic [TAG_W-1:0]   tag;
    logic [63:0]        transfer_offset;
    logic [31:0]        byte_count;
    logic [7:0]         op_code;
    logic [63:0]        buffer_address;
    logic [TIME_W-1:0]  now_time;
    logic signed [31:0] result_code;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [1:0]         entry_state;
    logic [COUNT_W-1:0] in_flight_count;
  } out_item_t;

  typedef struct packed {
    tag_state_t        state;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    tag_state_t        state;
    logic              stamp_en;
    logic [TIME_W-1:0] stamp;
  } mem_wr_t;

endpackage

>>> design/rtt_tag_mem.sv
module rtt_tag_mem (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [rtt_pkg::IDX_W-1:0] rd_idx,
  input  rtt_pkg::mem_wr_t        wr,
  output rtt_pkg::entry_t         rd
);

  rtt_pkg::tag_state_t             state_mem [rtt_pkg::DEPTH];
  logic [rtt_pkg::TIME_W-1:0]      stamp_mem [rtt_pkg::DEPTH];
  logic [rtt_pkg::DEPTH-1:0]       written;

  rtt_pkg::tag_state_t             rd_state;
  logic [rtt_pkg::TIME_W-1:0]      rd_stamp;
  logic                            rd_written;

  // Read data reflects the memory before a write at the same edge.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      state_mem[wr.idx] <= wr.state;
    end
    if (wr.stamp_en) begin
      stamp_mem[wr.idx] <= wr.stamp;
    end
    rd_state   <= state_mem[rd_idx];
    rd_stamp   <= stamp_mem[rd_idx];
    rd_written <= written[rd_idx];
  end

  // An entry never written since reset reads as waiting.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.idx] <= 1'b1;
    end
  end

  assign rd.state = rd_written ? rd_state : rtt_pkg::ST_WAITING;
  assign rd.stamp = rd_stamp;

endmodule

>>> design/rtt_event.sv
module rtt_event (
  input  logic                          valid,
  input  rtt_pkg::in_item_t             item,
  input  rtt_pkg::entry_t               cur,
  input  logic [rtt_pkg::DEPTH_W-1:0]   active_depth,
  input  logic [rtt_pkg::TIME_W-1:0]    timeout_limit,
  input  logic [rtt_pkg::COUNT_W-1:0]   in_flight,
  output rtt_pkg::mem_wr_t              wr,
  output rtt_pkg::out_item_t            result,
  output logic [rtt_pkg::COUNT_W-1:0]   in_flight_next
);

  logic                       in_table;
  logic                       in_active;
  logic                       expired;
  logic                       accepted;
  logic [rtt_pkg::TIME_W-1:0] elapsed;
  rtt_pkg::tag_state_t        state_next;
  rtt_pkg::tag_state_t        shown;

  assign in_table  = 32'(item.tag) < 32'(rtt_pkg::DEPTH);
  assign in_active = item.tag < {1'b0, active_depth};
  assign elapsed   = item.now_time - cur.stamp;
  assign expired   = (timeout_limit != '0) && (item.now_time >= cur.stamp) &&
                     (elapsed >= timeout_limit);

  always_comb begin
    accepted       = 1'b0;
    state_next     = cur.state;
    in_flight_next = in_flight;
    if (in_table && in_active) begin
      unique case (item.kind)
        rtt_pkg::KIND_START: begin
          if (cur.state == rtt_pkg::ST_WAITING) begin
            accepted       = 1'b1;
            state_next     = rtt_pkg::ST_TRANSFERRING;
            in_flight_next = in_flight + 1'b1;
          end
        end
        rtt_pkg::KIND_COMPLETE: begin
          if (cur.state == rtt_pkg::ST_TRANSFERRING) begin
            accepted       = 1'b1;
            state_next     = rtt_pkg::ST_COMPLETING;
            in_flight_next = in_flight - 1'b1;
          end
        end
        rtt_pkg::KIND_REARM: begin
          if (cur.state == rtt_pkg::ST_COMPLETING) begin
            accepted   = 1'b1;
            state_next = rtt_pkg::ST_WAITING;
          end
        end
        rtt_pkg::KIND_EXPIRY: begin
          if (cur.state == rtt_pkg::ST_TRANSFERRING && expired) begin
            accepted       = 1'b1;
            state_next     = rtt_pkg::ST_FAILED;
            in_flight_next = in_flight - 1'b1;
          end
        end
        default: begin
          accepted = 1'b0;
        end
      endcase
    end
  end

  // A tag past the table reports waiting; one past the active depth
  // reports its stored state.
  assign shown = in_table ? state_next : rtt_pkg::ST_WAITING;

  assign wr.en       = valid && accepted;
  assign wr.idx      = rtt_pkg::IDX_W'(item.tag);
  assign wr.state    = state_next;
  assign wr.stamp_en = valid && accepted && (item.kind == rtt_pkg::KIND_START);
  assign wr.stamp    = item.now_time;

  assign result.accepted        = accepted;
  assign result.entry_state     = shown;
  assign result.in_flight_count = in_flight_next;

endmodule

>>> design/request_tag_tracker.sv
// Request tag tracker: keeps the state of each I/O request tag.
// Event channel: an event is taken at a rising edge with start high and
// busy low. busy stays low, so one event can be taken in every cycle.
// Result channel: done is high for one cycle with the result of each event,
// in event order; the receiver must take it in that cycle.
// Pipeline: an event taken at a rising edge is registered into the event stage
// (s1_item), and its result is registered onto the ports together with done.
// Throughput: one event per cycle, set by
// the read-modify-write of the tag memory, which reads at the event edge and
// writes at the following edge, with the previous write forwarded to the next event.
// Configuration: cfg_ready is always high; index 0 sets the active depth
// (low 7 bits of the data), index 1 sets the timeout limit. Writes take effect
// at once; the user must make them only while no event is in progress (not enforced).
// Reset (rst, synchronous): all tags read as waiting through per-entry valid
// bits, so no clearing pass is needed; the in-flight count is zero, the active
// depth is 64 and the timeout limit is zero. Results are never held back.
`include "request_tag_tracker_defines.svh"

module request_tag_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  rtt_pkg::in_item_t           item,
  output logic                        done,
  output rtt_pkg::out_item_t          result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  rtt_pkg::cfg_reg_t           cfg_index,
  input  logic [rtt_pkg::CFG_W-1:0]   cfg_data
);

  logic [rtt_pkg::DEPTH_W-1:0] active_depth;
  logic [rtt_pkg::TIME_W-1:0]  timeout_limit;
  logic [rtt_pkg::COUNT_W-1:0] in_flight;
  logic [rtt_pkg::COUNT_W-1:0] in_flight_next;

  logic                        s1_valid;
  rtt_pkg::in_item_t           s1_item;

  logic                        fw_valid;
  logic [rtt_pkg::IDX_W-1:0]   fw_idx;
  rtt_pkg::entry_t             fw_entry;

  rtt_pkg::entry_t             mem_rd;
  rtt_pkg::entry_t             cur;
  rtt_pkg::mem_wr_t            mem_wr;
  rtt_pkg::out_item_t          step_result;
  logic                        take;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_depth  <= rtt_pkg::ACTIVE_DEPTH_RST;
      timeout_limit <= rtt_pkg::TIMEOUT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtt_pkg::REG_ACTIVE_DEPTH:  active_depth  <= cfg_data[rtt_pkg::DEPTH_W-1:0];
        rtt_pkg::REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        default:                    active_depth  <= active_depth;
      endcase
    end
  end

  rtt_tag_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rtt_pkg::IDX_W'(item.tag)),
    .wr     (mem_wr),
    .rd     (mem_rd)
  );

  // The memory read for this event was made while the previous event was
  // still being written, so that write is taken from the forward register.
  assign cur = (fw_valid && fw_idx == rtt_pkg::IDX_W'(s1_item.tag)) ? fw_entry : mem_rd;

  rtt_event u_event (
    .valid          (s1_valid),
    .item           (s1_item),
    .cur            (cur),
    .active_depth   (active_depth),
    .timeout_limit  (timeout_limit),
    .in_flight      (in_flight),
    .wr             (mem_wr),
    .result         (step_result),
    .in_flight_next (in_flight_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fw_valid  <= 1'b0;
      done      <= 1'b0;
      in_flight <= '0;
    end else begin
      s1_valid <= take;
      fw_valid <= mem_wr.en;
      done     <= s1_valid;
      if (s1_valid) begin
        in_flight <= in_flight_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= item;
    end
    fw_idx         <= mem_wr.idx;
    fw_entry.state <= mem_wr.state;
    fw_entry.stamp <= mem_wr.stamp_en ? mem_wr.stamp : cur.stamp;
    result         <= step_result;
  end

  `RTT_ASSERT_NEXT(a_result_follows_event, clk, rst, s1_valid, done, "event produced no result")
  `RTT_ASSERT_NEXT(a_refused_keeps_count, clk, rst, s1_valid && !mem_wr.en,
                   in_flight == $past(in_flight), "refused event changed the count")
  `RTT_ASSERT_SAME(a_write_needs_event, clk, rst, mem_wr.en, s1_valid,
                   "tag memory written without an event")
  `RTT_ASSERT_SAME(a_result_count_matches, clk, rst, done,
                   result.in_flight_count == in_flight, "result count differs from counter")

endmodule

>>> tb/sv/tb_request_tag_tracker.sv
module tb_request_tag_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import rtt_pkg::*;

  typedef enum logic {
    ROW_EVENT,
    ROW_CONFIG
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    in_item_t    ev;
    bit          typed;
    out_item_t   exp;
    cfg_reg_t    reg_idx;
    logic [63:0] reg_val;
  } stim_row_t;

  localparam int RAND_PHASES    = 6;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int RAND_ITEMS     = RAND_PHASES * ITEMS_PER_PHASE;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  in_item_t           item;
  logic               done;
  out_item_t          result;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_reg_t           cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  // Rows of the directed script may carry a hand-written expectation that
  // replaces the predicted one for the event in flight.
  logic               exp_typed;
  out_item_t          exp_typed_val;

  // Predictor state.
  tag_state_t         slot_state [DEPTH];
  logic [TIME_W-1:0]  slot_stamp [DEPTH];
  logic [COUNT_W-1:0] flight_total;
  logic [DEPTH_W-1:0] depth_reg;
  logic [TIME_W-1:0]  timeout_reg;

  out_item_t          pending_results [$];
  stim_row_t          script [$];
  int                 mismatch_count = 0;
  logic [63:0]        wall_ns = 64'd0;

  request_tag_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_item_t track_event(in_item_t ev);
    out_item_t  r;
    int         t;
    tag_state_t s;
    r = '0;
    if (ev.tag < DEPTH) begin
      t = int'(ev.tag);
      if (ev.tag < depth_reg) begin
        s = slot_state[t];
        case (ev.kind)
          KIND_START: begin
            if (s == ST_WAITING) begin
              slot_stamp[t] = ev.now_time;
              slot_state[t] = ST_TRANSFERRING;
              flight_total = flight_total + 1'b1;
              r.accepted = 1'b1;
            end
          end
          KIND_COMPLETE: begin
            if (s == ST_TRANSFERRING) begin
              slot_state[t] = ST_COMPLETING;
              flight_total = flight_total - 1'b1;
              r.accepted = 1'b1;
            end
          end
          KIND_REARM: begin
            if (s == ST_COMPLETING) begin
              slot_state[t] = ST_WAITING;
              r.accepted = 1'b1;
            end
          end
          default: begin
            // The stamp is compared before the elapsed time so that a check time behind
            // the start stamp never wraps into a huge elapsed time.
            if (timeout_reg != '0 && s == ST_TRANSFERRING &&
                ev.now_time >= slot_stamp[t] &&
                ev.now_time - slot_stamp[t] >= timeout_reg) begin
              slot_state[t] = ST_FAILED;
              flight_total = flight_total - 1'b1;
              r.accepted = 1'b1;
            end
          end
        endcase
      end
      r.entry_state = slot_state[t];
    end
    r.in_flight_count = flight_total;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst) begin
      foreach (slot_state[i]) begin
        slot_state[i] = ST_WAITING;
        slot_stamp[i] = '0;
      end
      flight_total = '0;
      depth_reg    = ACTIVE_DEPTH_RST;
      timeout_reg  = TIMEOUT_LIMIT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE_DEPTH:  depth_reg = cfg_data[DEPTH_W-1:0];
          REG_TIMEOUT_LIMIT: timeout_reg = cfg_data;
        endcase
      end
      if (start && !busy) begin
        want = track_event(item);
        if (exp_typed)
          want = exp_typed_val;
        pending_results.push_back(want);
      end
      if (done) begin
        got = result;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: accepted %0d state %0d count %0d",
                   $time, got.accepted, got.entry_state, got.in_flight_count);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch: expected %0d actual %0d",
                     $time, want.accepted, got.accepted);
            mismatch_count++;
          end
          if (got.entry_state !== want.entry_state) begin
            $display("%0t: entry_state mismatch: expected %0d actual %0d",
                     $time, want.entry_state, got.entry_state);
            mismatch_count++;
          end
          if (got.in_flight_count !== want.in_flight_count) begin
            $display("%0t: in_flight_count mismatch: expected %0d actual %0d",
                     $time, want.in_flight_count, got.in_flight_count);
            mismatch_count++;
          end
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_event(kind_t k, logic [7:0] tg, logic [63:0] now,
                           logic [31:0] res, bit fill, bit typed,
                           logic acc, tag_state_t st, int cnt);
    stim_row_t row;
    row.kind               = ROW_EVENT;
    row.ev.kind            = k;
    row.ev.tag             = tg;
    row.ev.transfer_offset = fill ? '1 : '0;
    row.ev.byte_count      = fill ? '1 : '0;
    row.ev.op_code         = fill ? '1 : '0;
    row.ev.buffer_address  = fill ? '1 : '0;
    row.ev.now_time        = now;
    row.ev.result_code     = res;
    row.typed              = typed;
    row.exp.accepted       = acc;
    row.exp.entry_state    = st;
    row.exp.in_flight_count = cnt[COUNT_W-1:0];
    row.reg_idx            = REG_ACTIVE_DEPTH;
    row.reg_val            = '0;
    script.push_back(row);
  endtask

  task automatic add_config(cfg_reg_t idx, logic [63:0] val);
    stim_row_t row;
    row.kind    = ROW_CONFIG;
    row.ev      = '0;
    row.typed   = 1'b0;
    row.exp     = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    script.push_back(row);
  endtask

  // Lowers start and waits until every transfer has produced its result.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Returns just after the rising edge at which the event was taken; start
  // stays high so that a following event can go out without a gap.
  task automatic send_event(in_item_t ev, bit typed, out_item_t exp, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    item          <= ev;
    exp_typed     <= typed;
    exp_typed_val <= exp;
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  function automatic logic [7:0] pick_tag();
    int          dep;
    int          r;
    logic [7:0]  t;
    dep = (depth_reg > DEPTH) ? DEPTH : depth_reg;
    r   = $urandom_range(99);
    if (r < 80 && dep > 0) begin
      // Failed tags never leave that state, so steer around them.
      t = 8'($urandom_range(dep - 1));
      for (int k = 0; k < 4 && slot_state[t] == ST_FAILED; k++)
        t = 8'($urandom_range(dep - 1));
    end else if (r < 90) begin
      t = 8'($urandom_range(DEPTH - 1));
    end else begin
      t = 8'($urandom_range(255));
    end
    return t;
  endfunction

  function automatic in_item_t make_random_event();
    in_item_t ev;
    ev.tag             = pick_tag();
    ev.transfer_offset = rand64();
    ev.byte_count      = $urandom();
    ev.op_code         = 8'($urandom_range(255));
    ev.buffer_address  = rand64();
    ev.result_code     = $urandom();
    wall_ns            = wall_ns + $urandom_range(400);
    ev.now_time        = ($urandom_range(19) == 0) ? rand64() : wall_ns;
    ev.kind            = kind_t'($urandom_range(3));
    if ($urandom_range(99) < 75 && ev.tag < DEPTH) begin
      case (slot_state[ev.tag])
        ST_WAITING:      ev.kind = KIND_START;
        ST_TRANSFERRING: ev.kind = ($urandom_range(99) < 10) ? KIND_EXPIRY : KIND_COMPLETE;
        ST_COMPLETING:   ev.kind = KIND_REARM;
        default:         ev.kind = kind_t'($urandom_range(3));
      endcase
    end
    return ev;
  endfunction

  initial begin
    logic [63:0] phase_depth   [RAND_PHASES];
    logic [63:0] phase_timeout [RAND_PHASES];
    in_item_t    ev;
    int          sent;
    int          idle_pct;

    rst           = 1'b1;
    start         = 1'b0;
    item          = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ACTIVE_DEPTH;
    cfg_data      = '0;
    exp_typed     = 1'b0;
    exp_typed_val = '0;

    // Directed script, starting from the reset settings.
    add_event(KIND_EXPIRY,   8'd0,   64'd0, 32'd0, 1'b0, 1'b1, 1'b0, ST_WAITING, 0);
    add_event(KIND_COMPLETE, 8'd0,   64'd0, 32'd5, 1'b0, 1'b1, 1'b0, ST_WAITING, 0);
    add_event(KIND_REARM,    8'd0,   64'd0, 32'd0, 1'b0, 1'b1, 1'b0, ST_WAITING, 0);
    // Tags past the end of the table read back as waiting.
    add_event(KIND_START,    8'd255, '1,    '1,    1'b1, 1'b1, 1'b0, ST_WAITING, 0);
    add_event(KIND_START,    8'd64,  '1,    '1,    1'b1, 1'b1, 1'b0, ST_WAITING, 0);
    add_event(KIND_START,    8'd0,   64'd0, 32'd0, 1'b0, 1'b1, 1'b1, ST_TRANSFERRING, 1);
    add_event(KIND_START,    8'd63,  '1,    '1,    1'b1, 1'b1, 1'b1, ST_TRANSFERRING, 2);
    add_event(KIND_START,    8'd0,   64'd9, 32'd0, 1'b0, 1'b1, 1'b0, ST_TRANSFERRING, 2);
    // Expiry is switched off while the timeout is zero.
    add_event(KIND_EXPIRY,   8'd0,   '1,    32'd1, 1'b0, 1'b1, 1'b0, ST_TRANSFERRING, 2);
    add_event(KIND_COMPLETE, 8'd63,  64'd0, 32'h8000_0000, 1'b0, 1'b1, 1'b1,
              ST_COMPLETING, 1);
    add_event(KIND_REARM,    8'd63,  64'd0, 32'd0, 1'b0, 1'b1, 1'b1, ST_WAITING, 1);
    add_event(KIND_REARM,    8'd63,  64'd0, 32'd0, 1'b0, 1'b1, 1'b0, ST_WAITING, 1);
    add_event(KIND_START,    8'd63,  64'd100, 32'd0, 1'b1, 1'b1, 1'b1, ST_TRANSFERRING, 2);
    add_config(REG_TIMEOUT_LIMIT, '1);
    add_event(KIND_EXPIRY,   8'd0,   '1,    32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, ST_FAILED, 1);
    // A check time behind the start stamp never expires the transfer.
    add_event(KIND_EXPIRY,   8'd63,  64'd50, 32'd3, 1'b0, 1'b1, 1'b0, ST_TRANSFERRING, 1);
    add_config(REG_TIMEOUT_LIMIT, 64'd1);
    add_event(KIND_EXPIRY,   8'd63,  64'd100, 32'd3, 1'b0, 1'b1, 1'b0, ST_TRANSFERRING, 1);
    add_event(KIND_EXPIRY,   8'd63,  64'd101, 32'd3, 1'b0, 1'b1, 1'b1, ST_FAILED, 0);
    add_config(REG_ACTIVE_DEPTH, 64'd0);
    add_event(KIND_START,    8'd5,   64'd0, 32'd0, 1'b0, 1'b1, 1'b0, ST_WAITING, 0);
    add_config(REG_ACTIVE_DEPTH, 64'd4);
    add_event(KIND_START,    8'd10,  64'd0, 32'd0, 1'b0, 1'b1, 1'b0, ST_WAITING, 0);
    add_event(KIND_START,    8'd3,   64'd7, 32'd0, 1'b1, 1'b1, 1'b1, ST_TRANSFERRING, 1);
    // Shrinking the depth leaves tag 3 in flight but refuses events on it.
    add_config(REG_ACTIVE_DEPTH, 64'd1);
    add_event(KIND_COMPLETE, 8'd3,   64'd0, 32'd0, 1'b0, 1'b1, 1'b0, ST_TRANSFERRING, 1);
    add_event(KIND_EXPIRY,   8'd3,   64'd1000, 32'd0, 1'b0, 1'b1, 1'b0, ST_TRANSFERRING, 1);
    add_config(REG_ACTIVE_DEPTH, 64'd64);
    add_config(REG_TIMEOUT_LIMIT, 64'd0);
    add_event(KIND_COMPLETE, 8'd3,   64'd0, 32'h1234, 1'b0, 1'b0, 1'b0, ST_WAITING, 0);
    add_event(KIND_REARM,    8'd3,   64'd0, 32'd0, 1'b0, 1'b0, 1'b0, ST_WAITING, 0);

    phase_depth   = '{64'd64, 64'd40, '1,  64'd12,  64'd64, 64'd33};
    phase_timeout = '{64'd1000, 64'd0, '1, 64'd300, 64'd50, 64'd1};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CONFIG) begin
        drain_results();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_event(script[i].ev, script[i].typed, script[i].exp, 33);
      end
    end

    wall_ns = 64'd200;
    sent    = 0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      write_reg(REG_ACTIVE_DEPTH, phase_depth[ph]);
      write_reg(REG_TIMEOUT_LIMIT, phase_timeout[ph]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (sent < RAND_ITEMS / 3)
          idle_pct = 33;
        else if (sent < 2 * RAND_ITEMS / 3)
          idle_pct = 55;
        else
          idle_pct = 0;
        // Hold off once mid-phase until the pipeline is empty.
        if (sent == 700)
          drain_results();
        ev = make_random_event();
        send_event(ev, 1'b0, '0, idle_pct);
        sent++;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("tb_request_tag_tracker: PASS");
    else
      $display("tb_request_tag_tracker: FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_request_tag_tracker: FAIL");
    $finish;
  end

endmodule
